/* rtl/core/mcspg_pkg.sv */
// Shared constants and types for the multi-channel servo pulse generator.
`timescale 1ns / 1ps

package mcspg_pkg;

  localparam int unsigned CHANNELS_DEF = 11;
  localparam int unsigned CHANNELS_MAX = 16;

  localparam int unsigned WIDTH_W = 12;
  localparam int unsigned ANGLE_W = 9;
  localparam int unsigned CHAN_W  = 4;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned FRAME_W = 13;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned IDLE_W  = 24;
  localparam int unsigned PINS_W  = 11;
  localparam int unsigned PROD_W  = 21;
  localparam int unsigned STEP_W  = 5;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [WIDTH_W-1:0] MIN_PULSE_RST = 12'd500;
  localparam logic [WIDTH_W-1:0] MAX_PULSE_RST = 12'd2500;
  localparam logic [ANGLE_W-1:0] MAX_ANGLE_RST = 9'd180;
  localparam logic [FRAME_W-1:0] FRAME_RST     = 13'd2500;
  localparam logic [IDLE_W-1:0]  TIMEOUT_RST   = 24'd125000;
  localparam logic [WIDTH_W-1:0] MID_PULSE     = 12'd1500;
  localparam logic [FRAME_W-1:0] FRAME_MAX     = 13'd4096;
  localparam logic [IDLE_W-1:0]  IDLE_MAX      = 24'hFFFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd4;

  localparam logic [STEP_W-1:0] MUL_LAST = 5'(ANGLE_W - 1);
  localparam logic [STEP_W-1:0] DIV_LAST = 5'(PROD_W - 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK   = 2'd0,
    KIND_SET    = 2'd1,
    KIND_ATTACH = 2'd2,
    KIND_DETACH = 2'd3
  } kind_e;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_MUL  = 6'b000100,
    S_DIV  = 6'b001000,
    S_FIN  = 6'b010000,
    S_EMIT = 6'b100000
  } state_e;

endpackage

/* rtl/core/multi_channel_servo_pulse_generator_core.sv */
// Servo pulse generator core: command decode, frame sequencing and serial angle mapping.
`timescale 1ns / 1ps

// Each input beat is a tick, a set-angle, an attach or a detach command; each gives one
// output beat with the pin levels and the pulse enable after the update. A tick scans
// the channels with one shared comparator that steps over them one per cycle.
// A set-angle on a valid channel runs a bit-serial multiply over the angle bits and a
// restoring divide (one quotient bit a cycle) that map the angle to a width.
// Attach, detach and set-angle on an ignored channel go straight to emit. A finished beat
// waits in the output register, so the next command is taken while it is unclaimed.
module multi_channel_servo_pulse_generator_core #(
  parameter int unsigned CHANNELS = mcspg_pkg::CHANNELS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mcspg_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mcspg_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [mcspg_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,  // channel[3:0], angle[12:4]
  input  logic [mcspg_pkg::KIND_W-1:0]        s_axis_tuser_i,  // kind[1:0]
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [mcspg_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o   // pin_levels[10:0], pulsing_on[11]
);

  localparam int unsigned ChW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned WW  = mcspg_pkg::WIDTH_W;
  localparam int unsigned AW  = mcspg_pkg::ANGLE_W;
  localparam int unsigned PW  = mcspg_pkg::PROD_W;

  mcspg_pkg::state_e state_q, state_d;

  logic [WW-1:0]                   min_q, min_d, max_q, max_d;
  logic [AW-1:0]                   mang_q, mang_d;
  logic [mcspg_pkg::FRAME_W-1:0]   frame_q, frame_d;
  logic [mcspg_pkg::IDLE_W-1:0]    tmo_q, tmo_d;

  logic [WW-1:0]                   width_q [CHANNELS];
  logic [WW-1:0]                   width_d [CHANNELS];
  logic [CHANNELS-1:0]             att_q, att_d;
  logic [CHANNELS-1:0]             pins_q, pins_d;
  logic [mcspg_pkg::POS_W-1:0]     fp_q, fp_d;
  logic                            en_q, en_d;
  logic [mcspg_pkg::IDLE_W-1:0]    idle_q, idle_d;

  logic [ChW-1:0]                  cnt_q, cnt_d, ch_q, ch_d;
  logic [mcspg_pkg::STEP_W-1:0]    step_q, step_d;
  logic [mcspg_pkg::POS_W+2:0]     pos_q, pos_d;
  logic                            neg_q, neg_d;
  logic [WW-1:0]                   mag_q, mag_d;
  logic [AW-1:0]                   ang_q, ang_d;
  logic [PW-1:0]                   acc_q, acc_d;
  logic [AW-1:0]                   rem_q, rem_d;

  logic                            ov_q, ov_d;
  logic [mcspg_pkg::PINS_W:0]      odat_q, odat_d;

  // combinational helpers
  mcspg_pkg::kind_e                kind;
  logic [mcspg_pkg::CHAN_W-1:0]    in_ch;
  logic [AW-1:0]                   in_ang;
  logic                            in_fire, ch_ok, en_n;
  logic [ChW-1:0]                  in_idx, rd_idx;
  logic [WW-1:0]                   rd_w, new_w;
  logic [mcspg_pkg::FRAME_W-1:0]   eff_frame, fp_inc;
  logic [AW-1:0]                   span;
  logic [WW:0]                     diff;
  logic [AW:0]                     trial;
  logic [PW:0]                     sum;
  logic [mcspg_pkg::PINS_W-1:0]    pin_lv;

  assign kind    = mcspg_pkg::kind_e'(s_axis_tuser_i);
  assign in_ch   = s_axis_tdata_i[3:0];
  assign in_ang  = s_axis_tdata_i[12:4];
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign ch_ok   = {1'b0, in_ch} < 5'(CHANNELS);
  assign in_idx  = in_ch[ChW-1:0];

  assign s_axis_tready_o = (state_q == mcspg_pkg::S_IDLE);
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = {{(mcspg_pkg::OUT_DATA_W - mcspg_pkg::PINS_W - 1){1'b0}}, odat_q};

  assign rd_idx = (state_q == mcspg_pkg::S_SCAN) ? cnt_q : ch_q;
  assign rd_w   = width_q[rd_idx];

  assign eff_frame = (frame_q == '0) ? mcspg_pkg::FRAME_W'(1) :
                     (frame_q > mcspg_pkg::FRAME_MAX) ? mcspg_pkg::FRAME_MAX : frame_q;
  assign fp_inc    = {1'b0, fp_q} + mcspg_pkg::FRAME_W'(1);
  assign span      = (mang_q == '0) ? AW'(1) : mang_q;
  assign diff      = {1'b0, max_q} - {1'b0, min_q};
  assign trial     = {rem_q, acc_q[PW-1]};
  assign sum       = {{(PW - WW + 1){1'b0}}, min_q} + {1'b0, acc_q};

  always_comb begin
    if (neg_q && (acc_q != '0)) begin
      new_w = min_q;
    end else if (sum > {{(PW - WW + 1){1'b0}}, max_q}) begin
      new_w = max_q;
    end else begin
      new_w = sum[WW-1:0];
    end
  end

  for (genvar g = 0; g < mcspg_pkg::PINS_W; g++) begin : g_pins
    if (g < CHANNELS) begin : g_on
      assign pin_lv[g] = pins_q[g];
    end else begin : g_off
      assign pin_lv[g] = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    min_d   = min_q;
    max_d   = max_q;
    mang_d  = mang_q;
    frame_d = frame_q;
    tmo_d   = tmo_q;
    width_d = width_q;
    att_d   = att_q;
    pins_d  = pins_q;
    fp_d    = fp_q;
    en_d    = en_q;
    idle_d  = idle_q;
    cnt_d   = cnt_q;
    ch_d    = ch_q;
    step_d  = step_q;
    pos_d   = pos_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    ang_d   = ang_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    ov_d    = ov_q;
    odat_d  = odat_q;
    en_n    = en_q;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        mcspg_pkg::CFG_MIN_PULSE: min_d   = cfg_data_i[WW-1:0];
        mcspg_pkg::CFG_MAX_PULSE: max_d   = cfg_data_i[WW-1:0];
        mcspg_pkg::CFG_MAX_ANGLE: mang_d  = cfg_data_i[AW-1:0];
        mcspg_pkg::CFG_FRAME:     frame_d = cfg_data_i[mcspg_pkg::FRAME_W-1:0];
        mcspg_pkg::CFG_TIMEOUT:   tmo_d   = cfg_data_i[mcspg_pkg::IDLE_W-1:0];
        default: ;
      endcase
    end

    if (ov_q && m_axis_tready_i) begin
      ov_d = 1'b0;
    end

    case (state_q)
      mcspg_pkg::S_IDLE: begin
        if (in_fire) begin
          case (kind)
            mcspg_pkg::KIND_TICK: begin
              if (fp_q == '0) begin
                en_n = en_q && !(idle_q > tmo_q);
                en_d = en_n;
                if (en_n) begin
                  pins_d = att_q;
                end
              end
              pos_d  = {fp_q, 3'b000};
              fp_d   = (fp_inc >= eff_frame) ? '0 : fp_inc[mcspg_pkg::POS_W-1:0];
              if (idle_q != mcspg_pkg::IDLE_MAX) begin
                idle_d = idle_q + mcspg_pkg::IDLE_W'(1);
              end
              cnt_d   = '0;
              state_d = mcspg_pkg::S_SCAN;
            end
            mcspg_pkg::KIND_SET: begin
              en_d = 1'b1;
              if (ch_ok) begin
                ch_d    = in_idx;
                ang_d   = in_ang;
                neg_d   = diff[WW];
                mag_d   = diff[WW] ? WW'(-diff) : diff[WW-1:0];
                acc_d   = '0;
                step_d  = '0;
                state_d = mcspg_pkg::S_MUL;
              end else begin
                state_d = mcspg_pkg::S_EMIT;
              end
            end
            mcspg_pkg::KIND_ATTACH: begin
              if (ch_ok) begin
                att_d[in_idx] = 1'b1;
              end
              state_d = mcspg_pkg::S_EMIT;
            end
            mcspg_pkg::KIND_DETACH: begin
              if (ch_ok) begin
                att_d[in_idx]  = 1'b0;
                pins_d[in_idx] = 1'b0;
              end
              state_d = mcspg_pkg::S_EMIT;
            end
            default: state_d = mcspg_pkg::S_EMIT;
          endcase
        end
      end
      mcspg_pkg::S_SCAN: begin
        if (att_q[cnt_q] && (pos_q > {3'b000, rd_w})) begin
          pins_d[cnt_q] = 1'b0;
        end
        if (cnt_q == ChW'(CHANNELS - 1)) begin
          state_d = mcspg_pkg::S_EMIT;
        end else begin
          cnt_d = cnt_q + ChW'(1);
        end
      end
      mcspg_pkg::S_MUL: begin
        // MSB-first shift-add over the angle bits
        acc_d  = {acc_q[PW-2:0], 1'b0} + (ang_q[AW-1] ? {{(PW - WW){1'b0}}, mag_q} : '0);
        ang_d  = {ang_q[AW-2:0], 1'b0};
        step_d = step_q + mcspg_pkg::STEP_W'(1);
        if (step_q == mcspg_pkg::MUL_LAST) begin
          step_d  = '0;
          rem_d   = '0;
          state_d = mcspg_pkg::S_DIV;
        end
      end
      mcspg_pkg::S_DIV: begin
        // restoring divide, quotient shifts into acc
        if (trial >= {1'b0, span}) begin
          rem_d = AW'(trial - {1'b0, span});
          acc_d = {acc_q[PW-2:0], 1'b1};
        end else begin
          rem_d = trial[AW-1:0];
          acc_d = {acc_q[PW-2:0], 1'b0};
        end
        step_d = step_q + mcspg_pkg::STEP_W'(1);
        if (step_q == mcspg_pkg::DIV_LAST) begin
          state_d = mcspg_pkg::S_FIN;
        end
      end
      mcspg_pkg::S_FIN: begin
        if (att_q[ch_q] && (new_w != rd_w)) begin
          width_d[ch_q] = new_w;
          idle_d        = '0;
        end
        state_d = mcspg_pkg::S_EMIT;
      end
      mcspg_pkg::S_EMIT: begin
        if (!ov_q || m_axis_tready_i) begin
          ov_d    = 1'b1;
          odat_d  = {en_q, pin_lv};
          state_d = mcspg_pkg::S_IDLE;
        end
      end
      default: state_d = mcspg_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcspg_pkg::S_IDLE;
      min_q   <= mcspg_pkg::MIN_PULSE_RST;
      max_q   <= mcspg_pkg::MAX_PULSE_RST;
      mang_q  <= mcspg_pkg::MAX_ANGLE_RST;
      frame_q <= mcspg_pkg::FRAME_RST;
      tmo_q   <= mcspg_pkg::TIMEOUT_RST;
      for (int i = 0; i < CHANNELS; i++) begin
        width_q[i] <= mcspg_pkg::MID_PULSE;
      end
      att_q   <= '0;
      pins_q  <= '0;
      fp_q    <= '0;
      en_q    <= 1'b0;
      idle_q  <= '0;
      cnt_q   <= '0;
      step_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      min_q   <= min_d;
      max_q   <= max_d;
      mang_q  <= mang_d;
      frame_q <= frame_d;
      tmo_q   <= tmo_d;
      width_q <= width_d;
      att_q   <= att_d;
      pins_q  <= pins_d;
      fp_q    <= fp_d;
      en_q    <= en_d;
      idle_q  <= idle_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
      ov_q    <= ov_d;
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    pos_q  <= pos_d;
    neg_q  <= neg_d;
    mag_q  <= mag_d;
    ang_q  <= ang_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    odat_q <= odat_d;
  end

endmodule
